FILE: rtl/ultrasonic_door_guidance_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Ultrasonic door guidance sequencer: assertion macros
// Concurrent assertion wrappers shared by the RTL; define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_DOOR_GUIDANCE_SEQUENCER_DEFINES_SVH
`define ULTRASONIC_DOOR_GUIDANCE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define UDGS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("udgs assertion failed");

// Check a property on every rising edge, reset included.
`define UDGS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("udgs assertion failed");

`else

`define UDGS_ASSERT(label, prop)
`define UDGS_ASSERT_ALWAYS(label, prop)

`endif

`endif

FILE: rtl/udgs_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic door guidance sequencer package
// Payload structs, register map, reset values and shared codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package udgs_pkg;

  localparam int REG_WIDTH       = 20;
  localparam int IDX_WIDTH       = 3;
  localparam int COUNT_WIDTH_DEF = 20;

  // Register map
  localparam logic [IDX_WIDTH-1:0] REG_TRIG_LOW     = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_TRIG_HIGH    = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_ECHO_TIMEOUT = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_MAX_PULSE    = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_BUS_NEAR     = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_DOOR_FULL    = 3'd5;
  localparam logic [IDX_WIDTH-1:0] REG_DOOR_MEDIUM  = 3'd6;
  localparam logic [IDX_WIDTH-1:0] REG_ROUND_PAUSE  = 3'd7;

  // Reset values
  localparam logic [REG_WIDTH-1:0] TRIG_LOW_RESET     = 20'd1000;
  localparam logic [REG_WIDTH-1:0] TRIG_HIGH_RESET    = 20'd2000;
  localparam logic [REG_WIDTH-1:0] ECHO_TIMEOUT_RESET = 20'd200000;
  localparam logic [REG_WIDTH-1:0] MAX_PULSE_RESET    = 20'd200000;
  localparam logic [REG_WIDTH-1:0] BUS_NEAR_RESET     = 20'd800;
  localparam logic [REG_WIDTH-1:0] DOOR_FULL_RESET    = 20'd2000;
  localparam logic [REG_WIDTH-1:0] DOOR_MEDIUM_RESET  = 20'd6000;
  localparam logic [REG_WIDTH-1:0] ROUND_PAUSE_RESET  = 20'd100000;

  // Sensor codes
  localparam logic [1:0] SEN_BUS    = 2'd0;
  localparam logic [1:0] SEN_A      = 2'd1;
  localparam logic [1:0] SEN_B      = 2'd2;
  localparam logic [1:0] SEN_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    LVL_FREE   = 2'd0,
    LVL_MEDIUM = 2'd1,
    LVL_FULL   = 2'd2
  } door_level_t;

  // Bit 0 is buzzer_a, bit 5 is led_b_green.
  typedef struct packed {
    logic led_b_green;
    logic led_b_red;
    logic led_a_green;
    logic led_a_red;
    logic buzzer_b;
    logic buzzer_a;
  } indicators_t;

  typedef struct packed {
    logic bus_echo;
    logic echo_door_a;
    logic echo_door_b;
  } item_t;

  typedef struct packed {
    logic bus_trig;
    logic trig_door_a;
    logic trig_door_b;
    logic buzzer_a;
    logic buzzer_b;
    logic led_a_red;
    logic led_a_green;
    logic led_b_red;
    logic led_b_green;
    logic round_done;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/ultrasonic_door_guidance_sequencer.sv
// ----------------------------------------------------------------------------
// Ultrasonic door guidance sequencer
// Tick-level echo ranging of a bus sensor and two door sensors, with
// buzzer and LED guidance toward the freer door.
// ----------------------------------------------------------------------------
// Each request is one timebase tick carrying the sampled echo pins. The block
// takes one request per clock cycle and presents its result in the next cycle
// from an output register; a new request is accepted in the same cycle that
// the previous result is taken, so the sustained rate is one tick per cycle,
// set by the single state update between the request and the result
// register. item_stall is high during reset and otherwise only while a result
// waits and result_stall is high. A round holds the active trigger low, pulses
// it, waits for the echo (timeout gives width 0), counts the echo width up to
// max_pulse_ticks, and repeats this for doors A and B only if the bus echo is
// near. Indicators hold until the next round ends; round_done marks that tick.
// Zero durations act as one, and durations beyond the COUNT_WIDTH range are
// clamped. Registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

`include "ultrasonic_door_guidance_sequencer_defines.svh"

module ultrasonic_door_guidance_sequencer
  import udgs_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [REG_WIDTH-1:0] cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result
);

  localparam int CW = COUNT_WIDTH;
  // Compare width covering both the counters and the registers
  localparam int LW = (CW > REG_WIDTH) ? CW : REG_WIDTH;
  localparam logic [LW-1:0] CountMax = LW'((64'd1 << CW) - 64'd1);

  typedef enum logic [2:0] {
    PH_TRIG_LOW   = 3'd0,
    PH_TRIG_HIGH  = 3'd1,
    PH_ECHO_WAIT  = 3'd2,
    PH_ECHO_COUNT = 3'd3,
    PH_PAUSE      = 3'd4
  } phase_t;

  // Clamp a duration register: zero acts as one, cap at the counter range.
  function automatic logic [LW-1:0] eff_limit(input logic [REG_WIDTH-1:0] v);
    logic [LW-1:0] x;
    x = LW'(v);
    if (v == '0) return LW'(1);
    if (x > CountMax) return CountMax;
    return x;
  endfunction

  function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] v);
    return (v == '1) ? v : v + CW'(1);
  endfunction

  function automatic door_level_t door_level(input logic [CW-1:0]        w,
                                             input logic [REG_WIDTH-1:0] full_thr,
                                             input logic [REG_WIDTH-1:0] med_thr);
    if (w == '0) return LVL_FREE;
    if (LW'(w) < LW'(full_thr)) return LVL_FULL;
    if (LW'(w) < LW'(med_thr)) return LVL_MEDIUM;
    return LVL_FREE;
  endfunction

  // Configuration registers
  logic [REG_WIDTH-1:0] trig_low_ticks;
  logic [REG_WIDTH-1:0] trig_high_ticks;
  logic [REG_WIDTH-1:0] echo_timeout_ticks;
  logic [REG_WIDTH-1:0] max_pulse_ticks;
  logic [REG_WIDTH-1:0] bus_near_threshold;
  logic [REG_WIDTH-1:0] door_full_threshold;
  logic [REG_WIDTH-1:0] door_medium_threshold;
  logic [REG_WIDTH-1:0] round_pause_ticks;

  // Sequencer state
  phase_t      phase;
  logic [1:0]  sensor;
  logic [CW-1:0] phase_cnt;
  logic [CW-1:0] echo_width;
  door_level_t door_a_level;
  indicators_t indicators;

  // First pass: the phase step without the end-of-measurement handling
  phase_t        phase_step;
  logic [1:0]    sensor_eff;
  logic [1:0]    sensor_step;
  logic [CW-1:0] cnt_step;
  logic [CW-1:0] width_step;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] width_inc;
  logic          echo;
  logic          trig;
  logic          finish;
  logic [CW-1:0] fin_width;

  // Second pass: final next values
  phase_t        phase_next;
  logic [1:0]    sensor_next;
  logic [CW-1:0] cnt_next;
  door_level_t   door_a_level_next;
  indicators_t   indicators_next;
  logic          done;
  result_t       result_next;

  door_level_t   fin_level;
  indicators_t   guide_ind;
  logic          accept;

  // Hold off requests during reset and while a waiting result is stalled.
  assign accept     = item_valid && !item_stall;
  assign item_stall = rst || (result_valid && result_stall);

  assign cnt_inc   = inc_sat(phase_cnt);
  assign width_inc = inc_sat(echo_width);

  always_comb begin
    // The unused sensor code behaves as the bus sensor.
    sensor_eff = (sensor == SEN_UNUSED) ? SEN_BUS : sensor;
    case (sensor_eff)
      SEN_A:   echo = item.echo_door_a;
      SEN_B:   echo = item.echo_door_b;
      default: echo = item.bus_echo;
    endcase

    phase_step  = phase;
    sensor_step = sensor_eff;
    cnt_step    = phase_cnt;
    width_step  = echo_width;
    trig        = 1'b0;
    finish      = 1'b0;
    fin_width   = echo_width;

    unique case (phase)
      PH_TRIG_LOW: begin
        cnt_step = cnt_inc;
        if (LW'(cnt_inc) >= eff_limit(trig_low_ticks)) begin
          cnt_step   = '0;
          phase_step = PH_TRIG_HIGH;
        end
      end
      PH_TRIG_HIGH: begin
        trig     = 1'b1;
        cnt_step = cnt_inc;
        if (LW'(cnt_inc) >= eff_limit(trig_high_ticks)) begin
          cnt_step   = '0;
          phase_step = PH_ECHO_WAIT;
        end
      end
      PH_ECHO_WAIT: begin
        if (echo) begin
          // The rising tick counts as one.
          width_step = CW'(1);
          cnt_step   = '0;
          fin_width  = CW'(1);
          if (LW'(1) >= eff_limit(max_pulse_ticks)) begin
            finish = 1'b1;
          end else begin
            phase_step = PH_ECHO_COUNT;
          end
        end else begin
          cnt_step = cnt_inc;
          if (LW'(cnt_inc) >= eff_limit(echo_timeout_ticks)) begin
            // No echo: report zero width.
            width_step = '0;
            fin_width  = '0;
            finish     = 1'b1;
          end
        end
      end
      PH_ECHO_COUNT: begin
        if (!echo) begin
          finish = 1'b1;
        end else begin
          width_step = width_inc;
          fin_width  = width_inc;
          if (LW'(width_inc) >= eff_limit(max_pulse_ticks)) begin
            finish = 1'b1;
          end
        end
      end
      PH_PAUSE: begin
        cnt_step = cnt_inc;
        if (LW'(cnt_inc) >= eff_limit(round_pause_ticks)) begin
          cnt_step    = '0;
          sensor_step = SEN_BUS;
          phase_step  = PH_TRIG_LOW;
        end
      end
      default: begin
        // Restart at trigger low from an unused phase code.
        cnt_step   = '0;
        phase_step = PH_TRIG_LOW;
      end
    endcase
  end

  assign fin_level = door_level(fin_width, door_full_threshold, door_medium_threshold);

  udgs_guidance u_guidance (
    .level_a    (door_a_level),
    .level_b    (fin_level),
    .indicators (guide_ind)
  );

  always_comb begin
    phase_next        = phase_step;
    sensor_next       = sensor_step;
    cnt_next          = cnt_step;
    door_a_level_next = door_a_level;
    indicators_next   = indicators;
    done              = 1'b0;

    if (finish) begin
      cnt_next = '0;
      case (sensor_eff)
        SEN_A: begin
          // Hold door A's level and move on to door B.
          door_a_level_next = fin_level;
          sensor_next       = SEN_B;
          phase_next        = PH_TRIG_LOW;
        end
        SEN_B: begin
          indicators_next = guide_ind;
          sensor_next     = SEN_BUS;
          phase_next      = PH_PAUSE;
          done            = 1'b1;
        end
        default: begin
          if (fin_width != '0 && LW'(fin_width) < LW'(bus_near_threshold)) begin
            // Bus near: range the doors.
            sensor_next = SEN_A;
            phase_next  = PH_TRIG_LOW;
          end else begin
            // No bus: clear all indicators.
            indicators_next = '0;
            sensor_next     = SEN_BUS;
            phase_next      = PH_PAUSE;
            done            = 1'b1;
          end
        end
      endcase
    end

    result_next.bus_trig    = trig && (sensor_eff == SEN_BUS);
    result_next.trig_door_a = trig && (sensor_eff == SEN_A);
    result_next.trig_door_b = trig && (sensor_eff == SEN_B);
    result_next.buzzer_a    = indicators_next.buzzer_a;
    result_next.buzzer_b    = indicators_next.buzzer_b;
    result_next.led_a_red   = indicators_next.led_a_red;
    result_next.led_a_green = indicators_next.led_a_green;
    result_next.led_b_red   = indicators_next.led_b_red;
    result_next.led_b_green = indicators_next.led_b_green;
    result_next.round_done  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_low_ticks        <= TRIG_LOW_RESET;
      trig_high_ticks       <= TRIG_HIGH_RESET;
      echo_timeout_ticks    <= ECHO_TIMEOUT_RESET;
      max_pulse_ticks       <= MAX_PULSE_RESET;
      bus_near_threshold    <= BUS_NEAR_RESET;
      door_full_threshold   <= DOOR_FULL_RESET;
      door_medium_threshold <= DOOR_MEDIUM_RESET;
      round_pause_ticks     <= ROUND_PAUSE_RESET;
      phase                 <= PH_TRIG_LOW;
      sensor                <= SEN_BUS;
      phase_cnt             <= '0;
      echo_width            <= '0;
      door_a_level          <= LVL_FREE;
      indicators            <= '0;
      result_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TRIG_LOW:     trig_low_ticks        <= cfg_data;
          REG_TRIG_HIGH:    trig_high_ticks       <= cfg_data;
          REG_ECHO_TIMEOUT: echo_timeout_ticks    <= cfg_data;
          REG_MAX_PULSE:    max_pulse_ticks       <= cfg_data;
          REG_BUS_NEAR:     bus_near_threshold    <= cfg_data;
          REG_DOOR_FULL:    door_full_threshold   <= cfg_data;
          REG_DOOR_MEDIUM:  door_medium_threshold <= cfg_data;
          REG_ROUND_PAUSE:  round_pause_ticks     <= cfg_data;
          default: ;
        endcase
      end

      // Advance the sequencer once per accepted tick.
      if (accept) begin
        phase        <= phase_next;
        sensor       <= sensor_next;
        phase_cnt    <= cnt_next;
        echo_width   <= width_step;
        door_a_level <= door_a_level_next;
        indicators   <= indicators_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end

    // Load the result register on accept; hold it otherwise.
    if (accept) begin
      result <= result_next;
    end
  end

  `UDGS_ASSERT(a_accept_gives_result, accept |=> result_valid)
  `UDGS_ASSERT(a_one_trigger,
    result_valid |-> $onehot0({result.bus_trig, result.trig_door_a, result.trig_door_b}))
  `UDGS_ASSERT(a_done_not_in_trigger,
    (result_valid && result.round_done) |->
      !(result.bus_trig || result.trig_door_a || result.trig_door_b))
  `UDGS_ASSERT(a_pause_on_bus, (phase == PH_PAUSE) |-> (sensor == SEN_BUS))
  `UDGS_ASSERT(a_sensor_code_used, sensor != SEN_UNUSED)

endmodule

`default_nettype wire

FILE: rtl/udgs_guidance.sv
// ----------------------------------------------------------------------------
// Door guidance rule
// Maps the occupancy levels of doors A and B onto buzzers and LEDs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udgs_guidance
  import udgs_pkg::*;
(
  input  door_level_t level_a,
  input  door_level_t level_b,
  output indicators_t indicators
);

  always_comb begin
    indicators = '0;
    if (level_a == LVL_FREE && level_b == LVL_FREE) begin
      indicators.buzzer_a = 1'b1;
      indicators.buzzer_b = 1'b1;
    end else if (level_a < level_b) begin
      // Steer toward A
      indicators.buzzer_a    = (level_a == LVL_FREE);
      indicators.led_b_green = 1'b1;
      indicators.led_a_red   = 1'b1;
      indicators.led_a_green = (level_b == LVL_MEDIUM);
    end else if (level_b < level_a) begin
      // Steer toward B
      indicators.buzzer_b    = (level_b == LVL_FREE);
      indicators.led_a_green = 1'b1;
      indicators.led_b_red   = 1'b1;
      indicators.led_b_green = (level_a == LVL_MEDIUM);
    end else if (level_a == LVL_MEDIUM) begin
      indicators.led_a_red   = 1'b1;
      indicators.led_a_green = 1'b1;
      indicators.led_b_red   = 1'b1;
      indicators.led_b_green = 1'b1;
    end
  end

endmodule

`default_nettype wire
